/* hdl/irn_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// irn_pkg
// Shared types, symbol tables and the microprogram for the Roman numeral
// converter.
// ----------------------------------------------------------------------------
package irn_pkg;

  localparam int unsigned ValueW  = 12;
  localparam int unsigned CharW   = 7;
  localparam int unsigned SymW    = 4;
  localparam int unsigned MaxValue = 3999;

  typedef logic [ValueW-1:0] value_t;
  typedef logic [CharW-1:0]  char_t;
  typedef logic [SymW-1:0]   sym_t;
  typedef logic [1:0]        step_t;

  localparam step_t S_IDLE  = 2'd0;
  localparam step_t S_CHECK = 2'd1;
  localparam step_t S_SCAN  = 2'd2;
  localparam step_t S_ERR   = 2'd3;

  localparam char_t CH_NONE = 7'd0;

  typedef enum logic [1:0] {
    C_ALWAYS = 2'd0,
    C_IN     = 2'd1,
    C_BAD    = 2'd2,
    C_GE     = 2'd3
  } cond_t;

  typedef enum logic [2:0] {
    U_NOP  = 3'd0,
    U_LOAD = 3'd1,
    U_ADV  = 3'd2,
    U_EMIT = 3'd3,
    U_ERR  = 3'd4
  } uop_t;

  typedef struct packed {
    cond_t cond;
    uop_t  op_true;
    step_t jump_true;
    uop_t  op_false;
    step_t jump_false;
    logic  hold_busy;
    logic  ret_last;
  } ucw_t;

  // datapath -> sequencer
  typedef struct packed {
    logic in_valid;
    logic bad;
    logic ge;
    logic out_free;
    logic last_letter;
  } stat_t;

  // sequencer -> datapath
  typedef struct packed {
    uop_t op;
    logic idle;
  } ctl_t;

  function automatic ucw_t ucode(step_t s);
    ucw_t w;
    unique case (s)
      S_IDLE: begin
        w.cond = C_IN;     w.op_true = U_LOAD; w.jump_true = S_CHECK;
        w.op_false = U_NOP; w.jump_false = S_IDLE;
        w.hold_busy = 1'b0; w.ret_last = 1'b0;
      end
      S_CHECK: begin
        w.cond = C_BAD;    w.op_true = U_NOP;  w.jump_true = S_ERR;
        w.op_false = U_NOP; w.jump_false = S_SCAN;
        w.hold_busy = 1'b0; w.ret_last = 1'b0;
      end
      S_SCAN: begin
        w.cond = C_GE;     w.op_true = U_EMIT; w.jump_true = S_SCAN;
        w.op_false = U_ADV; w.jump_false = S_SCAN;
        w.hold_busy = 1'b1; w.ret_last = 1'b1;
      end
      S_ERR: begin
        w.cond = C_ALWAYS; w.op_true = U_ERR;  w.jump_true = S_IDLE;
        w.op_false = U_ERR; w.jump_false = S_IDLE;
        w.hold_busy = 1'b1; w.ret_last = 1'b0;
      end
      default: begin
        w.cond = C_ALWAYS; w.op_true = U_NOP;  w.jump_true = S_IDLE;
        w.op_false = U_NOP; w.jump_false = S_IDLE;
        w.hold_busy = 1'b0; w.ret_last = 1'b0;
      end
    endcase
    return w;
  endfunction

  function automatic value_t sym_weight(sym_t s);
    value_t v;
    unique case (s)
      4'd0:    v = 12'd1000;
      4'd1:    v = 12'd900;
      4'd2:    v = 12'd500;
      4'd3:    v = 12'd400;
      4'd4:    v = 12'd100;
      4'd5:    v = 12'd90;
      4'd6:    v = 12'd50;
      4'd7:    v = 12'd40;
      4'd8:    v = 12'd10;
      4'd9:    v = 12'd9;
      4'd10:   v = 12'd5;
      4'd11:   v = 12'd4;
      4'd12:   v = 12'd1;
      default: v = 12'd1;
    endcase
    return v;
  endfunction

  function automatic char_t sym_first(sym_t s);
    char_t c;
    unique case (s)
      4'd0:    c = 7'h4D; // M
      4'd1:    c = 7'h43; // C
      4'd2:    c = 7'h44; // D
      4'd3:    c = 7'h43; // C
      4'd4:    c = 7'h43; // C
      4'd5:    c = 7'h58; // X
      4'd6:    c = 7'h4C; // L
      4'd7:    c = 7'h58; // X
      4'd8:    c = 7'h58; // X
      4'd9:    c = 7'h49; // I
      4'd10:   c = 7'h56; // V
      4'd11:   c = 7'h49; // I
      4'd12:   c = 7'h49; // I
      default: c = 7'h49;
    endcase
    return c;
  endfunction

  function automatic char_t sym_second(sym_t s);
    char_t c;
    unique case (s)
      4'd1:    c = 7'h4D; // CM
      4'd3:    c = 7'h44; // CD
      4'd5:    c = 7'h43; // XC
      4'd7:    c = 7'h4C; // XL
      4'd9:    c = 7'h58; // IX
      4'd11:   c = 7'h56; // IV
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* hdl/irn_useq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// irn_useq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module irn_useq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire irn_pkg::stat_t stat,
  output irn_pkg::ctl_t      ctl
);
  import irn_pkg::*;

  step_t pc_r, pc_nxt;
  ucw_t  w;
  logic  c;
  uop_t  op_sel;
  step_t tgt;
  logic  is_emit;

  always_comb begin
    w = ucode(pc_r);
    unique case (w.cond)
      C_ALWAYS: c = 1'b1;
      C_IN:     c = stat.in_valid;
      C_BAD:    c = stat.bad;
      C_GE:     c = stat.ge;
      default:  c = 1'b0;
    endcase
    op_sel  = c ? w.op_true : w.op_false;
    tgt     = c ? w.jump_true : w.jump_false;
    is_emit = (op_sel == U_EMIT) || (op_sel == U_ERR);

    ctl.idle = (pc_r == S_IDLE);
    priority if (w.hold_busy && is_emit && !stat.out_free) begin
      ctl.op = U_NOP;
      pc_nxt = pc_r;
    end else if (w.ret_last && (op_sel == U_EMIT) && stat.last_letter) begin
      ctl.op = op_sel;
      pc_nxt = S_IDLE;
    end else begin
      ctl.op = op_sel;
      pc_nxt = tgt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule
`default_nettype wire

/* hdl/integer_to_roman.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_roman
// Converts a binary integer to its Roman numeral, one ASCII letter per
// output transaction, with a last mark and a range error flag.
//
//   channel | direction | payload
//   in_     | input     | value[11:0]
//   out_    | output    | numeral_char[6:0], last, range_error
//
// One number at a time. The idle step loads the number, the check step tests
// its range, then the scan step emits one letter per cycle while the output
// is not stalled and skips symbols that do not fit (at most 12); a number
// gives up to 15 letters. Synchronous reset clears the step counter and the
// output valid. out_stall holds the sequencer on its emitting step.
// ----------------------------------------------------------------------------
module integer_to_roman (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire irn_pkg::value_t       in_value,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output irn_pkg::char_t             out_numeral_char,
  output logic                       out_last,
  output logic                       out_range_error
);
  import irn_pkg::*;

  stat_t  stat;
  ctl_t   ctl;

  value_t rest_r, rest_nxt;
  sym_t   sym_r, sym_nxt;
  logic   half_r, half_nxt;
  logic   out_valid_r, out_valid_nxt;
  char_t  out_char_r, out_char_nxt;
  logic   out_last_r, out_last_nxt;
  logic   out_err_r, out_err_nxt;

  value_t w;
  char_t  ch_first, ch_second, ch;
  logic   fin;

  irn_useq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  always_comb begin
    w         = sym_weight(sym_r);
    ch_first  = sym_first(sym_r);
    ch_second = sym_second(sym_r);
    ch        = half_r ? ch_second : ch_first;
    fin       = half_r || (ch_second == CH_NONE);

    stat.in_valid    = in_valid;
    stat.bad         = (rest_r == '0) || (rest_r > value_t'(MaxValue));
    stat.ge          = half_r || (rest_r >= w);
    stat.out_free    = !out_valid_r || !out_stall;
    stat.last_letter = fin && (rest_r == w);
  end

  always_comb begin
    rest_nxt      = rest_r;
    sym_nxt       = sym_r;
    half_nxt      = half_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    unique case (ctl.op)
      U_NOP: begin
      end
      U_LOAD: begin
        rest_nxt = in_value;
        sym_nxt  = '0;
        half_nxt = 1'b0;
      end
      U_ADV: begin
        sym_nxt = sym_r + sym_t'(1);
      end
      U_EMIT: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = ch;
        out_last_nxt  = stat.last_letter;
        out_err_nxt   = 1'b0;
        if (fin) begin
          rest_nxt = rest_r - w;
          half_nxt = 1'b0;
        end else begin
          half_nxt = 1'b1;
        end
      end
      U_ERR: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = CH_NONE;
        out_last_nxt  = 1'b1;
        out_err_nxt   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rest_r     <= rest_nxt;
    sym_r      <= sym_nxt;
    half_r     <= half_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign in_stall         = !ctl.idle;
  assign out_valid        = out_valid_r;
  assign out_numeral_char = out_char_r;
  assign out_last         = out_last_r;
  assign out_range_error  = out_err_r;

endmodule
`default_nettype wire

/* bench/integer_to_roman_tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_roman_tb
// Self-checking bench for the Roman numeral converter. Numbers go in through
// the valid/stall input channel, and each accepted transaction is expanded by
// a digit-by-digit predictor into the letters it should produce. Every output
// transaction is compared with the oldest expected letter. The stimulus covers
// corner values, out-of-range numbers, long numerals, random idling on both
// channels and a long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module integer_to_roman_tb;

  import irn_pkg::*;

  localparam int unsigned ResetCycles = 11;
  localparam int unsigned DrainCycles = 32;
  localparam int unsigned HoldCycles  = 250;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned PrintLimit  = 100;

  localparam char_t LetterM = 7'h4D;
  localparam char_t LetterD = 7'h44;
  localparam char_t LetterC = 7'h43;
  localparam char_t LetterL = 7'h4C;
  localparam char_t LetterX = 7'h58;
  localparam char_t LetterV = 7'h56;
  localparam char_t LetterI = 7'h49;

  typedef struct packed {
    char_t letter;
    logic  last;
    logic  range_error;
  } roman_letter_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  value_t in_value = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  char_t  out_numeral_char;
  logic   out_last;
  logic   out_range_error;

  roman_letter_t pending_letters[$];
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;
  logic          recv_hold = 1'b0;

  integer_to_roman dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_numeral_char (out_numeral_char),
    .out_last         (out_last),
    .out_range_error  (out_range_error)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < PrintLimit)
      $display("%0t mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Expands a number into its letters one decimal place at a time.
  function automatic void predict_numeral(input value_t number);
    char_t       letters[$];
    char_t       one;
    char_t       five;
    char_t       ten;
    int unsigned rest;
    int unsigned digit;
    int unsigned scale;
    int          place;
    roman_letter_t item;
    if (number < 1 || number > MaxValue) begin
      item.letter = CH_NONE;
      item.last = 1'b1;
      item.range_error = 1'b1;
      pending_letters.push_back(item);
      return;
    end
    rest = number;
    for (place = 3; place >= 0; place--) begin
      case (place)
        3: begin
          one = LetterM; five = CH_NONE; ten = CH_NONE; scale = 1000;
        end
        2: begin
          one = LetterC; five = LetterD; ten = LetterM; scale = 100;
        end
        1: begin
          one = LetterX; five = LetterL; ten = LetterC; scale = 10;
        end
        default: begin
          one = LetterI; five = LetterV; ten = LetterX; scale = 1;
        end
      endcase
      digit = rest / scale;
      rest = rest % scale;
      if (digit == 9) begin
        letters.push_back(one);
        letters.push_back(ten);
      end else if (digit == 4) begin
        letters.push_back(one);
        letters.push_back(five);
      end else begin
        if (digit >= 5) begin
          letters.push_back(five);
          digit -= 5;
        end
        repeat (digit) letters.push_back(one);
      end
    end
    foreach (letters[k]) begin
      item.letter = letters[k];
      item.last = (k == letters.size() - 1);
      item.range_error = 1'b0;
      pending_letters.push_back(item);
    end
  endfunction

  function automatic value_t random_number();
    value_t v;
    case ($urandom_range(0, 9))
      0: begin
        if ($urandom_range(0, 3) == 0)
          v = '0;
        else
          v = value_t'($urandom_range(MaxValue + 1, 4095));
      end
      1: v = value_t'($urandom_range(0, 3) * 1000 + $urandom_range(5, 8) * 100 +
                      $urandom_range(5, 8) * 10 + $urandom_range(5, 8));
      default: v = value_t'($urandom_range(1, MaxValue));
    endcase
    return v;
  endfunction

  // Leaves in_valid high on return; the caller lowers it when done.
  task automatic send_number(input value_t number);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= number;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_numeral(number);
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (pending_letters.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  always @(posedge clk) begin
    out_stall <= recv_hold || ($urandom_range(0, 99) < recv_idle_pct);
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_letters.size() == 0) begin
        report_mismatch($sformatf("unexpected letter %h", out_numeral_char));
      end else begin
        if (out_numeral_char !== pending_letters[0].letter)
          report_mismatch($sformatf("letter %h, expected %h",
                                    out_numeral_char, pending_letters[0].letter));
        if (out_last !== pending_letters[0].last)
          report_mismatch($sformatf("last %b, expected %b",
                                    out_last, pending_letters[0].last));
        if (out_range_error !== pending_letters[0].range_error)
          report_mismatch($sformatf("range_error %b, expected %b",
                                    out_range_error, pending_letters[0].range_error));
        void'(pending_letters.pop_front());
      end
    end
  end

  task automatic test_corner_values();
    value_t corners[$];
    corners = '{12'd1, 12'd2, 12'd3, 12'd4, 12'd5, 12'd9, 12'd10, 12'd40,
                12'd49, 12'd90, 12'd99, 12'd400, 12'd444, 12'd500, 12'd900,
                12'd999, 12'd1000, 12'd1994, 12'd3888, 12'd3999, 12'd0,
                12'd4000, 12'd4095, 12'd2048};
    foreach (corners[k]) send_number(corners[k]);
    wait_until_drained();
  endtask

  task automatic test_random_numbers(input int unsigned count);
    repeat (count) send_number(random_number());
    wait_until_drained();
  endtask

  task automatic test_output_holdoff(input int unsigned count);
    fork
      begin
        recv_hold <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        recv_hold <= 1'b0;
      end
      begin
        repeat (count) send_number(random_number());
        in_valid <= 1'b0;
      end
    join
    wait_until_drained();
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    set_idling(9, 53);
    test_corner_values();
    test_random_numbers(50);
    set_idling(53, 9);
    test_random_numbers(50);
    set_idling(0, 0);
    test_random_numbers(36);
    test_output_holdoff(20);
    if (pending_letters.size() != 0)
      report_mismatch($sformatf("%0d letters never arrived", pending_letters.size()));
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
